@@ hdl/multi_encoding_char_splitter_defines.svh @@
// Assertion macros shared by the character splitter RTL.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in the using module.
`ifndef MULTI_ENCODING_CHAR_SPLITTER_DEFINES_SVH
`define MULTI_ENCODING_CHAR_SPLITTER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset.
`define MECS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define MECS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define MECS_ASSERT_NOW(lbl, ante, cons)
`define MECS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ hdl/mecs_pkg.sv @@
// Shared types and constants for the character splitter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mecs_pkg;

    typedef enum logic [2:0] {
        ENC_ANSI    = 3'd0,
        ENC_UCS2LE  = 3'd1,
        ENC_UCS2BE  = 3'd2,
        ENC_UTF32LE = 3'd3,
        ENC_UTF32BE = 3'd4,
        ENC_UTF8    = 3'd5,
        ENC_UTF16LE = 3'd6,
        ENC_UTF16BE = 3'd7
    } t_encoding;

    // High byte range of a UTF-16 high surrogate (0xD800..0xDBFF).
    localparam logic [7:0] SURR_HI_MIN = 8'hD8;
    localparam logic [7:0] SURR_HI_MAX = 8'hDB;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [31:0] gathered;
        logic [2:0]  nbytes;
        logic        bad;
        t_encoding   enc;
    } t_char_entry;

    typedef struct packed {
        logic        valid;
        t_char_entry entry;
    } t_q_push;

endpackage

@@ hdl/mecs_front.sv @@
// Front end: accepts bytes, finds character boundaries and gathers raw bytes.
// Depends on mecs_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "multi_encoding_char_splitter_defines.svh"

module mecs_front
    import mecs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  t_encoding   i_encoding,
    input  logic        i_accept,
    input  logic [7:0]  i_data_byte,
    output t_q_push     o_push
);

    logic [31:0] r_gath, n_gath;
    logic [2:0]  r_seen, n_seen;
    logic [2:0]  r_exp,  n_exp;

    logic        start;
    logic [2:0]  lead_len;
    logic [2:0]  utf8_len;
    logic [31:0] gath_base;
    logic [31:0] gath_new;
    logic [2:0]  seen_base;
    logic [2:0]  seen_new;
    logic [2:0]  exp_base;
    logic [2:0]  exp_new;
    logic [7:0]  hi_byte;
    logic        surr;

    always_comb begin
        priority if (i_data_byte[7] == 1'b0) begin
            utf8_len = 3'd1;
        end else if (i_data_byte[7:5] == 3'b110) begin
            utf8_len = 3'd2;
        end else if (i_data_byte[7:4] == 4'b1110) begin
            utf8_len = 3'd3;
        end else if (i_data_byte[7:3] == 5'b11110) begin
            utf8_len = 3'd4;
        end else begin
            utf8_len = 3'd0;
        end
    end

    always_comb begin
        unique case (i_encoding)
            ENC_ANSI:                 lead_len = 3'd1;
            ENC_UCS2LE, ENC_UCS2BE:   lead_len = 3'd2;
            ENC_UTF32LE, ENC_UTF32BE: lead_len = 3'd4;
            ENC_UTF8:                 lead_len = utf8_len;
            default:                  lead_len = 3'd2;
        endcase
    end

    always_comb begin
        start     = (r_exp == 3'd0);
        gath_base = start ? 32'd0 : r_gath;
        seen_base = start ? 3'd0 : r_seen;
        exp_base  = start ? lead_len : r_exp;
        gath_new  = gath_base | ({24'd0, i_data_byte} << {seen_base[1:0], 3'b000});
        seen_new  = seen_base + 3'd1;

        // Surrogate test on the first UTF-16 unit: high byte depends on byte order.
        hi_byte = (i_encoding == ENC_UTF16LE) ? gath_new[15:8] : gath_new[7:0];
        surr    = (hi_byte >= SURR_HI_MIN) && (hi_byte <= SURR_HI_MAX)
                  && ((i_encoding == ENC_UTF16LE) || (i_encoding == ENC_UTF16BE));
        exp_new = (seen_new == 3'd2 && exp_base == 3'd2 && surr) ? 3'd4 : exp_base;

        n_gath = r_gath;
        n_seen = r_seen;
        n_exp  = r_exp;
        o_push = '0;

        if (i_accept) begin
            if (start && lead_len == 3'd0) begin
                // Drop an invalid lead byte; report it and stay idle.
                o_push.valid        = 1'b1;
                o_push.entry.nbytes = 3'd1;
                o_push.entry.bad    = 1'b1;
                o_push.entry.enc    = i_encoding;
            end else if (seen_new >= exp_new) begin
                o_push.valid          = 1'b1;
                o_push.entry.gathered = gath_new;
                o_push.entry.nbytes   = exp_new;
                o_push.entry.enc      = i_encoding;
                n_gath = 32'd0;
                n_seen = 3'd0;
                n_exp  = 3'd0;
            end else begin
                n_gath = gath_new;
                n_seen = seen_new;
                n_exp  = exp_new;
            end
        end

        if (i_cfg_we) begin
            n_gath = 32'd0;
            n_seen = 3'd0;
            n_exp  = 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gath <= 32'd0;
            r_seen <= 3'd0;
            r_exp  <= 3'd0;
        end else begin
            r_gath <= n_gath;
            r_seen <= n_seen;
            r_exp  <= n_exp;
        end
    end

    `MECS_ASSERT_NOW(a_idle_no_seen, r_exp == 3'd0, r_seen == 3'd0)
    `MECS_ASSERT_NOW(a_seen_below_exp, r_exp != 3'd0, r_seen < r_exp && r_exp <= 3'd4)

endmodule

@@ hdl/mecs_queue.sv @@
// Short queue that decouples the front end from the back end.
// Depends on mecs_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "multi_encoding_char_splitter_defines.svh"

module mecs_queue
    import mecs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_q_push     i_push,
    input  logic        i_pop,
    output logic        o_full,
    output logic        o_valid,
    output t_char_entry o_entry
);

    t_char_entry r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wptr, n_wptr;
    logic [Q_AW-1:0] r_rptr, n_rptr;
    logic [Q_CW-1:0] r_count, n_count;

    assign o_full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rptr];

    always_comb begin
        n_wptr  = i_push.valid ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = i_pop ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count + Q_CW'(i_push.valid) - Q_CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wptr] <= i_push.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    `MECS_ASSERT_NOW(a_no_overflow, i_push.valid, !o_full)
    `MECS_ASSERT_NOW(a_no_underflow, i_pop, o_valid)
    `MECS_ASSERT_NOW(a_count_range, 1'b1, r_count <= Q_CW'(Q_DEPTH))

endmodule

@@ hdl/mecs_back.sv @@
// Back end: packs gathered bytes per encoding into the output register.
// Depends on mecs_pkg.
`timescale 1ns / 1ps

module mecs_back
    import mecs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_char_entry i_q_entry,
    output logic        o_q_pop,
    input  logic        i_out_stall,
    output logic        o_out_valid,
    output logic [31:0] o_char_value,
    output logic [2:0]  o_char_bytes,
    output logic        o_bad_lead
);

    logic        r_out_valid;
    logic [31:0] r_char_value, n_char_value;
    logic [2:0]  r_char_bytes;
    logic        r_bad_lead;
    logic [31:0] g;
    logic [31:0] sw16;
    logic [31:0] sw32;
    logic [2:0]  sh;

    assign o_q_pop = i_q_valid && (!r_out_valid || !i_out_stall);

    always_comb begin
        g    = i_q_entry.gathered;
        sw16 = {16'd0, g[7:0], g[15:8]};
        sw32 = {g[7:0], g[15:8], g[23:16], g[31:24]};
        sh   = 3'd4 - i_q_entry.nbytes;
        unique case (i_q_entry.enc)
            ENC_ANSI:    n_char_value = {24'd0, g[7:0]};
            ENC_UCS2LE:  n_char_value = {16'd0, g[15:0]};
            ENC_UCS2BE:  n_char_value = sw16;
            ENC_UTF32LE: n_char_value = g;
            ENC_UTF32BE: n_char_value = sw32;
            ENC_UTF8:    n_char_value = g << {sh[1:0], 3'b000};
            ENC_UTF16LE: n_char_value = (i_q_entry.nbytes == 3'd2) ? {16'd0, g[15:0]} : g;
            ENC_UTF16BE: n_char_value = (i_q_entry.nbytes == 3'd2) ? sw16 : sw32;
            default:     n_char_value = g;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_char_value <= n_char_value;
            r_char_bytes <= i_q_entry.nbytes;
            r_bad_lead   <= i_q_entry.bad;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_char_value = r_char_value;
    assign o_char_bytes = r_char_bytes;
    assign o_bad_lead   = r_bad_lead;

endmodule

@@ hdl/multi_encoding_char_splitter.sv @@
// Top level of the multi-encoding character splitter.
// Depends on mecs_pkg, mecs_front, mecs_queue, mecs_back and the assertion macros header.
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+------------------------------------
//   input    | i_in_valid / o_in_stall      | i_data_byte[7:0]
//   output   | o_out_valid / i_out_stall    | o_char_value, o_char_bytes, o_bad_lead
//   config   | i_cfg_we                     | i_cfg_data[2:0] (encoding)
//
// Flow: one byte transfer per cycle sustained while the queue has room; a character's result
//   is written into the queue when its last byte transfers and moves into the output
//   register from there when that register is empty or its result is being taken.
// Reset: synchronous, active low; encoding returns to ANSI, no character in progress.
// Stalls: the input stalls only while the four-entry queue between front and back
//   is full; an output stall holds the result and lets the queue fill behind it.
`timescale 1ns / 1ps
`include "multi_encoding_char_splitter_defines.svh"

module multi_encoding_char_splitter
    import mecs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_char_value,
    output logic [2:0]  o_char_bytes,
    output logic        o_bad_lead
);

    t_encoding   r_encoding;
    logic        in_accept;
    logic        q_full;
    logic        q_valid;
    logic        q_pop;
    t_char_entry q_entry;
    t_q_push     push;

    // Hold the encoding register; a write also abandons any partial character.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_encoding <= ENC_ANSI;
        end else if (i_cfg_we) begin
            r_encoding <= t_encoding'(i_cfg_data);
        end
    end

    // Stall input while the queue has no room; every byte may finish a character.
    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !q_full;

    mecs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_encoding  (r_encoding),
        .i_accept    (in_accept),
        .i_data_byte (i_data_byte),
        .o_push      (push)
    );

    mecs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    mecs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_entry    (q_entry),
        .o_q_pop      (q_pop),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_char_value (o_char_value),
        .o_char_bytes (o_char_bytes),
        .o_bad_lead   (o_bad_lead)
    );

    // A result leaves the queue only when the output register can take it.
    `MECS_ASSERT_NOW(a_pop_needs_room, q_pop, q_valid && (!o_out_valid || !i_out_stall))
    // A popped entry shows up as a valid result in the next cycle.
    `MECS_ASSERT_NEXT(a_pop_shows, q_pop, o_out_valid)

endmodule

@@ verif/multi_encoding_char_splitter_tb.sv @@
// Self-checking testbench for the multi-encoding character splitter.
// Needs mecs_pkg and the multi_encoding_char_splitter RTL; nothing else.
`timescale 1ns / 1ps

module multi_encoding_char_splitter_tb;
    import mecs_pkg::*;

    localparam int TOTAL_BYTES    = 1400;  // byte transfers over the whole run
    localparam int QUIET_TAIL     = 150;   // last bytes sent with no idling anywhere
    localparam int HOLD_CYCLES    = 160;   // long output hold-off that fills the block
    localparam int DRAIN_CYCLES   = 6;     // extra wait for stray results after the last owed one
    // Longest correct stretch without any transfer is the hold-off plus a few
    // stall bursts and a config pause; the limit is set well above that.
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  nbytes;
        logic        bad;
    } t_char_result;

    // One row of the directed table: either an encoding write or one byte.
    // Rows with known set carry the result typed in; others use the predictor.
    typedef struct packed {
        logic         is_cfg;
        t_encoding    enc;
        logic [7:0]   data;
        logic         known;
        t_char_result want;
    } t_dir_row;

    localparam t_char_result NO_RES  = '{32'h0, 3'd0, 1'b0};
    localparam t_char_result BAD_RES = '{32'h0, 3'd1, 1'b1};

    localparam int DIR_ROWS = 31;
    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        // ANSI straight out of reset: both byte extremes
        '{1'b0, ENC_ANSI,    8'h00, 1'b1, '{32'h0000_0000, 3'd1, 1'b0}},
        '{1'b0, ENC_ANSI,    8'hFF, 1'b1, '{32'h0000_00FF, 3'd1, 1'b0}},
        // UTF-8: one-byte char lands in the top byte, invalid leads, then two- and four-byte chars
        '{1'b1, ENC_UTF8,    8'h00, 1'b0, NO_RES},
        '{1'b0, ENC_UTF8,    8'h7F, 1'b1, '{32'h7F00_0000, 3'd1, 1'b0}},
        '{1'b0, ENC_UTF8,    8'h80, 1'b1, BAD_RES},
        '{1'b0, ENC_UTF8,    8'hF8, 1'b1, BAD_RES},
        '{1'b0, ENC_UTF8,    8'hC3, 1'b0, NO_RES},
        '{1'b0, ENC_UTF8,    8'hA9, 1'b0, NO_RES},
        '{1'b0, ENC_UTF8,    8'hF0, 1'b0, NO_RES},
        '{1'b0, ENC_UTF8,    8'h9F, 1'b0, NO_RES},
        '{1'b0, ENC_UTF8,    8'h98, 1'b0, NO_RES},
        '{1'b0, ENC_UTF8,    8'h80, 1'b0, NO_RES},
        // three-byte lead left hanging, then abandoned by the encoding write
        '{1'b0, ENC_UTF8,    8'hE2, 1'b0, NO_RES},
        '{1'b1, ENC_UTF16LE, 8'h00, 1'b0, NO_RES},
        // lowest high surrogate followed by lowest low surrogate
        '{1'b0, ENC_UTF16LE, 8'h00, 1'b0, NO_RES},
        '{1'b0, ENC_UTF16LE, 8'hD8, 1'b0, NO_RES},
        '{1'b0, ENC_UTF16LE, 8'h00, 1'b0, NO_RES},
        '{1'b0, ENC_UTF16LE, 8'hDC, 1'b0, NO_RES},
        // highest high surrogate, big-endian
        '{1'b1, ENC_UTF16BE, 8'h00, 1'b0, NO_RES},
        '{1'b0, ENC_UTF16BE, 8'hDB, 1'b0, NO_RES},
        '{1'b0, ENC_UTF16BE, 8'hFF, 1'b0, NO_RES},
        '{1'b0, ENC_UTF16BE, 8'hDF, 1'b0, NO_RES},
        '{1'b0, ENC_UTF16BE, 8'hFF, 1'b0, NO_RES},
        // UCS-2 never pairs surrogates
        '{1'b1, ENC_UCS2BE,  8'h00, 1'b0, NO_RES},
        '{1'b0, ENC_UCS2BE,  8'hD8, 1'b0, NO_RES},
        '{1'b0, ENC_UCS2BE,  8'h00, 1'b0, NO_RES},
        '{1'b1, ENC_UTF32BE, 8'h00, 1'b0, NO_RES},
        '{1'b0, ENC_UTF32BE, 8'hFF, 1'b0, NO_RES},
        '{1'b0, ENC_UTF32BE, 8'h00, 1'b0, NO_RES},
        '{1'b0, ENC_UTF32BE, 8'h00, 1'b0, NO_RES},
        '{1'b0, ENC_UTF32BE, 8'h01, 1'b0, NO_RES}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_data_byte;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_char_value;
    logic [2:0]  o_char_bytes;
    logic        o_bad_lead;

    // Predictor state: encoding and the character being gathered.
    t_encoding   cur_enc;
    logic [31:0] acc_bytes;
    logic [2:0]  got_count;
    logic [2:0]  want_count;

    t_char_result pending_chars [$];   // results still owed by the block
    int unsigned  errors      = 0;
    int unsigned  bytes_sent  = 0;
    int unsigned  idle_cycles = 0;
    bit           quiet       = 1'b0;  // no idling on either side
    bit           hold_req    = 1'b0;  // ask the output side for a long hold-off
    bit           hold_on     = 1'b0;

    multi_encoding_char_splitter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_data_byte  (i_data_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_char_value (o_char_value),
        .o_char_bytes (o_char_bytes),
        .o_bad_lead   (o_bad_lead)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Advance the segmenter by one accepted byte; report a finished character.
    function automatic void segment_byte(input logic [7:0] b, output bit emitted,
                                         output t_char_result res);
        logic [2:0]  n;
        logic [7:0]  hi;
        logic [31:0] rev;
        emitted = 1'b0;
        res     = NO_RES;
        if (want_count == 3'd0) begin
            case (cur_enc)
                ENC_ANSI:                  n = 3'd1;
                ENC_UTF32LE, ENC_UTF32BE:  n = 3'd4;
                ENC_UTF8: begin
                    casez (b)
                        8'b0???????: n = 3'd1;
                        8'b110?????: n = 3'd2;
                        8'b1110????: n = 3'd3;
                        8'b11110???: n = 3'd4;
                        default:     n = 3'd0;
                    endcase
                end
                default:                   n = 3'd2;
            endcase
            // Invalid UTF-8 lead: flag it, drop the byte, stay idle.
            if (n == 3'd0) begin
                emitted = 1'b1;
                res     = BAD_RES;
                return;
            end
            want_count = n;
            got_count  = 3'd0;
            acc_bytes  = 32'h0;
        end
        acc_bytes[8 * got_count[1:0] +: 8] = b;
        got_count = got_count + 3'd1;
        // A UTF-16 high surrogate stretches the character to four bytes.
        if (got_count == 3'd2 && want_count == 3'd2) begin
            hi = (cur_enc == ENC_UTF16LE) ? acc_bytes[15:8] : acc_bytes[7:0];
            if ((cur_enc == ENC_UTF16LE || cur_enc == ENC_UTF16BE) &&
                hi >= SURR_HI_MIN && hi <= SURR_HI_MAX)
                want_count = 3'd4;
        end
        if (got_count >= want_count) begin
            rev = {acc_bytes[7:0], acc_bytes[15:8], acc_bytes[23:16], acc_bytes[31:24]};
            case (cur_enc)
                ENC_ANSI:    res.value = {24'h0, acc_bytes[7:0]};
                ENC_UCS2LE:  res.value = {16'h0, acc_bytes[15:0]};
                ENC_UCS2BE:  res.value = {16'h0, acc_bytes[7:0], acc_bytes[15:8]};
                ENC_UTF32LE: res.value = acc_bytes;
                ENC_UTF32BE: res.value = rev;
                ENC_UTF8:    res.value = acc_bytes << (8 * (4 - int'(want_count)));
                ENC_UTF16LE: res.value = (want_count == 3'd2) ?
                                         {16'h0, acc_bytes[15:0]} : acc_bytes;
                default:     res.value = (want_count == 3'd2) ?
                                         {16'h0, acc_bytes[7:0], acc_bytes[15:8]} : rev;
            endcase
            res.nbytes = want_count;
            res.bad    = 1'b0;
            emitted    = 1'b1;
            acc_bytes  = 32'h0;
            got_count  = 3'd0;
            want_count = 3'd0;
        end
    endfunction

    task automatic idle_input(input int n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Idle the input a while now and then, outside the quiet tail.
    task automatic maybe_idle();
        if (!quiet && $urandom_range(0, 7) == 0)
            idle_input($urandom_range(1, 18));
    endtask

    // Offer one byte and hold it until the transfer.
    task automatic push_byte(input logic [7:0] b, output bit emitted,
                             output t_char_result res);
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_in_stall);
        segment_byte(b, emitted, res);
        bytes_sent++;
    endtask

    task automatic feed(input logic [7:0] b);
        bit           emitted;
        t_char_result res;
        push_byte(b, emitted, res);
        if (emitted)
            pending_chars.push_back(res);
        maybe_idle();
    endtask

    task automatic feed_unit(input logic [15:0] u);
        if (cur_enc == ENC_UTF16LE) begin
            feed(u[7:0]);
            feed(u[15:8]);
        end else begin
            feed(u[15:8]);
            feed(u[7:0]);
        end
    endtask

    // One well-formed character with random content, or a stray noise byte.
    task automatic feed_char();
        int          len;
        logic [15:0] unit;
        if ($urandom_range(0, 9) == 0) begin
            feed(8'($urandom));
            return;
        end
        case (cur_enc)
            ENC_ANSI:                 feed(8'($urandom));
            ENC_UCS2LE, ENC_UCS2BE:   repeat (2) feed(8'($urandom));
            ENC_UTF32LE, ENC_UTF32BE: repeat (4) feed(8'($urandom));
            ENC_UTF8: begin
                len = $urandom_range(1, 4);
                case (len)
                    1:       feed({1'b0, 7'($urandom)});
                    2:       feed({3'b110, 5'($urandom)});
                    3:       feed({4'b1110, 4'($urandom)});
                    default: feed({5'b11110, 3'($urandom)});
                endcase
                repeat (len - 1) feed({2'b10, 6'($urandom)});
            end
            default: begin
                unit = 16'($urandom);
                if ($urandom_range(0, 2) == 0)
                    unit = {6'b110110, 10'($urandom)};
                feed_unit(unit);
                if (unit[15:10] == 6'b110110)
                    feed_unit({6'b110111, 10'($urandom)});
            end
        endcase
    endtask

    // Write the encoding only once the block has nothing left to deliver.
    task automatic set_encoding(input t_encoding e);
        i_in_valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= e;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        // A write drops any half-gathered character.
        cur_enc    = e;
        acc_bytes  = 32'h0;
        got_count  = 3'd0;
        want_count = 3'd0;
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    // Compare every output transfer against the oldest owed result.
    always @(posedge i_clk) begin
        t_char_result exp_char;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_chars.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual value %h bytes %0d bad %b",
                         $time, o_char_value, o_char_bytes, o_bad_lead);
            end else begin
                exp_char = pending_chars.pop_front();
                check_field("char_value", exp_char.value, o_char_value);
                check_field("char_bytes", 32'(exp_char.nbytes), 32'(o_char_bytes));
                check_field("bad_lead", 32'(exp_char.bad), 32'(o_bad_lead));
            end
        end
    end

    // Count cycles with no transfer on either channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("multi_encoding_char_splitter_tb failed");
        $finish;
    end

    // Output side: random stall bursts, one long hold-off on request,
    // and no stalls at all once the quiet tail starts.
    initial begin : out_side
        i_out_stall = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                hold_on  = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_on  = 1'b0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
        end
    end

    initial begin : in_side
        bit           emitted;
        t_char_result res;
        int           phase;
        int unsigned  phase_end;
        t_encoding    enc;

        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = ENC_ANSI;
        i_in_valid  = 1'b0;
        i_data_byte = 8'h00;
        cur_enc     = ENC_ANSI;
        acc_bytes   = 32'h0;
        got_count   = 3'd0;
        want_count  = 3'd0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table.
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (DIRECTED[r].is_cfg) begin
                set_encoding(DIRECTED[r].enc);
            end else begin
                push_byte(DIRECTED[r].data, emitted, res);
                if (DIRECTED[r].known)
                    pending_chars.push_back(DIRECTED[r].want);
                else if (emitted)
                    pending_chars.push_back(res);
                maybe_idle();
            end
        end

        // Hold off the output for a long stretch while ANSI bytes keep coming,
        // so the queue fills and the input stalls.
        set_encoding(ENC_ANSI);
        hold_req = 1'b1;
        while (!hold_on) @(posedge i_clk);
        repeat (40) feed(8'($urandom));

        // Random phases: every encoding in turn first, then random ones.
        phase = 0;
        while (bytes_sent < TOTAL_BYTES) begin
            enc = (phase < 8) ? t_encoding'(phase) : t_encoding'($urandom_range(0, 7));
            set_encoding(enc);
            phase_end = bytes_sent + $urandom_range(30, 90);
            while (bytes_sent < phase_end && bytes_sent < TOTAL_BYTES) begin
                quiet = (bytes_sent >= TOTAL_BYTES - QUIET_TAIL);
                feed_char();
            end
            phase++;
        end

        // Drain: wait for every owed result, then a little longer for strays.
        i_in_valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0)
            $display("multi_encoding_char_splitter_tb passed");
        else
            $display("multi_encoding_char_splitter_tb failed");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/mecs_pkg.sv
hdl/mecs_front.sv
hdl/mecs_queue.sv
hdl/mecs_back.sv
hdl/multi_encoding_char_splitter.sv
verif/multi_encoding_char_splitter_tb.sv
